// ----- rtl/core/lbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int MAX_FIELD_BITS = 64;
  localparam int VAL_W          = 64;
  localparam int CNT_W          = 7;
  localparam int BYTE_W         = 8;
  localparam int PEND_W         = BYTE_W - 1;
  localparam int ACC_W          = VAL_W + PEND_W;
  localparam int NB_W           = 4;   // byte count per word, 0..9
  localparam int PCNT_W         = 3;

  typedef struct packed {
    logic [VAL_W-1:0] field_value;
    logic [CNT_W-1:0] bit_count;
    logic             end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_end;
    logic              stream_end;
  } out_item_t;

  // classified word: count clamped, value masked to its count
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             flush;
  } work_item_t;

  typedef struct packed {
    logic       valid;
    work_item_t item;
  } queue_out_t;

endpackage

// ----- rtl/core/lbp_front.sv -----
// ----------------------------------------------------------------------------
// lbp_front
// Accepts input words, clamps and masks them, and buffers them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lbp_front import lbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_data,
  output queue_out_t q_out,
  input  logic       q_take
);

  work_item_t       slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             acc_in;
  logic             take_ok;
  logic [CNT_W-1:0] cnt_clamp;
  logic [VAL_W-1:0] mask;
  work_item_t       cls;

  always_comb begin
    if (in_data.bit_count > CNT_W'(MAX_FIELD_BITS)) begin
      cnt_clamp = CNT_W'(MAX_FIELD_BITS);
    end else begin
      cnt_clamp = in_data.bit_count;
    end
    if (cnt_clamp >= CNT_W'(VAL_W)) begin
      mask = '1;
    end else begin
      mask = (VAL_W'(1) << cnt_clamp) - VAL_W'(1);
    end
    cls.value = in_data.field_value & mask;
    cls.count = cnt_clamp;
    cls.flush = in_data.end_of_stream;
  end

  assign full    = (cnt_r == 2'd2);
  assign acc_in  = push && !full;
  assign take_ok = q_take && (cnt_r != 2'd0);

  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = acc_in  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(acc_in) - 2'(take_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- rtl/core/lbp_back.sv -----
// ----------------------------------------------------------------------------
// lbp_back
// Merges each word with the pending partial byte and drains the result
// one byte per cycle, while the output register is free, through the output register.
// ----------------------------------------------------------------------------
module lbp_back import lbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  queue_out_t q_out,
  output logic       q_take,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_data
);

  logic [ACC_W-1:0]  shreg_r, shreg_nxt;
  logic [NB_W-1:0]   left_r, left_nxt;
  logic              flush_r, flush_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              slot_free;
  logic              emit;
  logic              load;
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;
  logic [ACC_W-1:0]  merged;
  logic [CNT_W-1:0]  total;
  logic [NB_W-1:0]   nbytes;

  assign slot_free = !out_valid_r || pop;
  assign emit      = (left_r != '0) && slot_free;
  // next word may load in the cycle its predecessor's last byte goes out
  assign load      = q_out.valid &&
                     ((left_r == '0) || ((left_r == NB_W'(1)) && emit));
  assign q_take    = load;

  always_comb begin
    if (flush_r) begin
      pend_bits = '0;
    end else if (left_r == NB_W'(1)) begin
      pend_bits = shreg_r[BYTE_W +: PEND_W];
    end else begin
      pend_bits = shreg_r[PEND_W-1:0];
    end
    pend_cnt = pcnt_r;
    merged   = (ACC_W'(q_out.item.value) << pend_cnt) | ACC_W'(pend_bits);
    total    = q_out.item.count + CNT_W'(pend_cnt);
    nbytes   = NB_W'(total[CNT_W-1:PCNT_W]) +
               NB_W'(q_out.item.flush && (total[PCNT_W-1:0] != '0));
  end

  always_comb begin
    shreg_nxt     = shreg_r;
    left_nxt      = left_r;
    flush_nxt     = flush_r;
    pcnt_nxt      = pcnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_valid_r || pop) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.out_byte   = shreg_r[BYTE_W-1:0];
      out_data_nxt.run_end    = (left_r == NB_W'(1));
      out_data_nxt.stream_end = (left_r == NB_W'(1)) && flush_r;
      shreg_nxt               = shreg_r >> BYTE_W;
      left_nxt                = left_r - NB_W'(1);
    end
    if (load) begin
      shreg_nxt = merged;
      left_nxt  = nbytes;
      flush_nxt = q_out.item.flush;
      pcnt_nxt  = q_out.item.flush ? '0 : total[PCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shreg_r     <= '0;
      left_r      <= '0;
      flush_r     <= 1'b0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      shreg_r     <= shreg_nxt;
      left_r      <= left_nxt;
      flush_r     <= flush_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

endmodule

// ----- rtl/core/lsb_first_bit_packer_unit.sv -----
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_unit
// Appends the low bit_count bits of each word to an LSB-first byte stream.
// ----------------------------------------------------------------------------
// Each input word completes up to 8 bytes, or 9 when end_of_stream flushes
// a padded partial byte. The byte drain of the back end moves one byte per
// cycle, while the output register is free, from the merge shift register
// into the single output register. A two-entry queue sits between the input
// classifier and the drain, so new words are taken while bytes of earlier
// ones are still going out. Words that complete no byte are absorbed and
// produce nothing.
module lsb_first_bit_packer_unit import lbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  queue_out_t q_out;
  logic       q_take;

  lbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_out   (q_out),
    .q_take  (q_take)
  );

  lbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_out    (q_out),
    .q_take   (q_take),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

`ifndef SYNTH
  // a stream end always closes the word's run
  a_stream_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.stream_end) |-> out_data.run_end)
    else $error("stream_end without run_end");

  // a full queue must be presenting a word to the back end
  a_full_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_out.valid)
    else $error("queue full but no word offered");

  // nothing pending or queued right after reset
  a_reset_clear: assert property (@(posedge clk)
    !$past(rst_n) |-> (empty && !full && !q_out.valid))
    else $error("state not clear after reset");
`endif

endmodule

// ----- tb/tb_lsb_first_bit_packer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_packer_unit
// Self-checking bench for the LSB-first bit packer. Words are pushed through
// the input queue with random gaps. A built-in model packs the same words
// into bytes and keeps the bytes still due. Every popped byte is checked
// against the oldest due byte, field by field. It covers field extremes,
// count saturation, flush corner cases, a long output stall that fills the
// block, and random streams with and without idle cycles.
// ----------------------------------------------------------------------------
module tb_lsb_first_bit_packer_unit;
  import lbp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 16;
  localparam int HOLD_CYCLES = 150;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  // packer model state
  logic [PEND_W-1:0] model_pend_bits;
  logic [PCNT_W-1:0] model_pend_cnt;
  out_item_t         due_bytes[$];

  int err_count;
  int cycle_count;
  int tx_max_gap;
  int rx_max_gap;
  bit rx_hold_req;

  lsb_first_bit_packer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
               due_bytes.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Appends one accepted word to the model stream and queues the bytes it
  // completes (plus the padded partial byte on a flush).
  function automatic void pack_word(input in_item_t w);
    logic [71:0]       wide;
    logic [VAL_W-1:0]  masked;
    logic [BYTE_W-1:0] bytes[$];
    logic [BYTE_W-1:0] partial;
    out_item_t         b;
    int                cnt;
    int                total;
    int                nfull;
    int                rem;
    cnt = (w.bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(w.bit_count);
    masked = (cnt == VAL_W) ? w.field_value
                            : (w.field_value & ((64'd1 << cnt) - 64'd1));
    wide = {65'd0, model_pend_bits} | ({8'd0, masked} << model_pend_cnt);
    total = int'(model_pend_cnt) + cnt;
    nfull = total / BYTE_W;
    rem = total % BYTE_W;
    for (int k = 0; k < nfull; k++)
      bytes.push_back(wide[BYTE_W*k +: BYTE_W]);
    // bits above the stream end are already zero, so this is the padded byte
    partial = wide[BYTE_W*nfull +: BYTE_W];
    if (w.end_of_stream && rem > 0)
      bytes.push_back(partial);
    for (int k = 0; k < bytes.size(); k++) begin
      b.out_byte   = bytes[k];
      b.run_end    = (k == bytes.size() - 1);
      b.stream_end = w.end_of_stream && (k == bytes.size() - 1);
      due_bytes.push_back(b);
    end
    if (w.end_of_stream) begin
      model_pend_bits = '0;
      model_pend_cnt  = '0;
    end else begin
      model_pend_bits = partial[PEND_W-1:0];
      model_pend_cnt  = PCNT_W'(rem);
    end
  endfunction

  // Offers one word after a random gap and returns at the edge that takes it.
  // push stays high on return so back-to-back words keep it up.
  task automatic send_word(input logic [VAL_W-1:0] value, input logic [CNT_W-1:0] count,
                           input logic eos);
    in_item_t w;
    int       gap;
    w.field_value   = value;
    w.bit_count     = count;
    w.end_of_stream = eos;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    pack_word(w);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = $urandom_range(rx_max_gap, 0);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (due_bytes.size() == 0) begin
        if (err_count < 10)
          $display("unexpected byte: got byte=%02h run_end=%0b stream_end=%0b",
                   out_data.out_byte, out_data.run_end, out_data.stream_end);
        err_count++;
      end else begin
        want = due_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.run_end !== want.run_end ||
            out_data.stream_end !== want.stream_end) begin
          if (err_count < 10)
            $display({"byte mismatch: exp byte=%02h run_end=%0b stream_end=%0b,",
                      " got byte=%02h run_end=%0b stream_end=%0b"},
                     want.out_byte, want.run_end, want.stream_end,
                     out_data.out_byte, out_data.run_end, out_data.stream_end);
          err_count++;
        end
      end
    end
  end

  task automatic test_field_extremes();
    send_word('1, 7'd64, 1'b0);
    send_word('0, 7'd64, 1'b0);
    send_word(64'haaaa_aaaa_aaaa_aaaa, 7'd64, 1'b0);
    send_word(64'h5555_5555_5555_5555, 7'd64, 1'b1);
    // unaligned pending bits plus a full word plus flush: nine bytes
    send_word('1, 7'd3, 1'b0);
    send_word(64'h0123_4567_89ab_cdef, 7'd64, 1'b1);
    send_word('1, 7'd1, 1'b0);
    send_word('0, 7'd7, 1'b0);
    send_word('1, 7'd1, 1'b1);
  endtask

  task automatic test_special_cases();
    // stray high bits above the count
    send_word(64'hffff_ffff_ffff_fff2, 7'd4, 1'b0);
    send_word(64'hdead_beef_cafe_f00d, 7'd12, 1'b0);
    // counts above the maximum saturate
    send_word(64'hfedc_ba98_7654_3210, 7'd65, 1'b0);
    send_word(64'h8000_0000_0000_0001, 7'd127, 1'b0);
    send_word('1, 7'd96, 1'b1);
    // zero count: nothing, then a flush with nothing pending
    send_word('1, 7'd0, 1'b0);
    send_word('1, 7'd0, 1'b1);
    // zero count flushing a partial byte
    send_word(64'h5, 7'd3, 1'b0);
    send_word('1, 7'd0, 1'b1);
    // flush with nothing left over after full bytes
    send_word(64'h00_00a5, 7'd8, 1'b1);
    send_word(64'h3c_3c3c, 7'd5, 1'b0);
    send_word(64'hffff, 7'd11, 1'b1);
    send_word(64'h7f, 7'd7, 1'b0);
    send_word(64'h1, 7'd1, 1'b0);
  endtask

  // output held off while the input keeps offering wide words
  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    tx_max_gap = 0;
    for (int i = 0; i < 14; i++)
      send_word({$urandom, $urandom}, (i % 3 == 0) ? 7'd61 : 7'd64, i == 13);
    tx_max_gap = 10;
  endtask

  // streams of words usually closed by an end-of-stream word, with some noise
  task automatic test_random_streams(input int n_words);
    logic [CNT_W-1:0] cnt;
    logic             eos;
    int               sent;
    int               len;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len && sent < n_words; i++) begin
        case ($urandom_range(9, 0))
          0:       cnt = CNT_W'($urandom_range(127, 65));
          1:       cnt = 7'd64;
          2, 3:    cnt = CNT_W'($urandom_range(7, 0));
          default: cnt = CNT_W'($urandom_range(64, 0));
        endcase
        if (i == len - 1)
          eos = ($urandom_range(9, 0) != 0);
        else
          eos = ($urandom_range(15, 0) == 0);
        send_word({$urandom, $urandom}, cnt, eos);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    in_data         = '0;
    model_pend_bits = '0;
    model_pend_cnt  = '0;
    err_count       = 0;
    cycle_count     = 0;
    tx_max_gap      = 10;
    rx_max_gap      = 10;
    rx_hold_req     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_special_cases();
    test_backpressure();
    test_random_streams(50);
    tx_max_gap = 0;
    rx_max_gap = 0;
    test_random_streams(30);
    tx_max_gap = 10;
    rx_max_gap = 10;
    test_random_streams(53);

    push <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- lsb_first_bit_packer_unit.f -----
rtl/core/lbp_pkg.sv
rtl/core/lbp_front.sv
rtl/core/lbp_back.sv
rtl/core/lsb_first_bit_packer_unit.sv
tb/tb_lsb_first_bit_packer_unit.sv
